// File: hw/rtl/three_voice_sound_generator_assert.svh
// Assertion helpers for the sound generator.
`ifndef THREE_VOICE_SOUND_GENERATOR_ASSERT_SVH
`define THREE_VOICE_SOUND_GENERATOR_ASSERT_SVH

// Property must hold at every rising clock edge out of reset.
`define TVSG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a rising clock edge out of reset.
`define TVSG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/tvsg_pkg.sv
package tvsg_pkg;

  localparam int unsigned MAX_VOICES     = 3;
  localparam int unsigned VOICES_DEFAULT = 3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SELECT = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  // register map
  localparam logic [3:0] REG_TONE_A_LO = 4'd0;
  localparam logic [3:0] REG_TONE_A_HI = 4'd1;
  localparam logic [3:0] REG_TONE_B_LO = 4'd2;
  localparam logic [3:0] REG_TONE_B_HI = 4'd3;
  localparam logic [3:0] REG_TONE_C_LO = 4'd4;
  localparam logic [3:0] REG_TONE_C_HI = 4'd5;
  localparam logic [3:0] REG_NOISE_PER = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_A     = 4'd8;
  localparam logic [3:0] REG_VOL_B     = 4'd9;
  localparam logic [3:0] REG_VOL_C     = 4'd10;
  localparam logic [3:0] REG_ENV_LO    = 4'd11;
  localparam logic [3:0] REG_ENV_HI    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

  // envelope shape bits
  localparam int unsigned SHAPE_HOLD      = 0;
  localparam int unsigned SHAPE_ALTERNATE = 1;
  localparam int unsigned SHAPE_ATTACK    = 2;
  localparam int unsigned SHAPE_CONTINUE  = 3;

  localparam int unsigned VOL_ENV_BIT = 4;

  typedef struct packed {
    logic tick;
    logic shape_we;
  } env_ctrl_t;

endpackage

// File: hw/rtl/tvsg_tone.sv
module tvsg_tone (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  logic [15:0] period_i,
  output logic        tone_o
);

  logic [15:0] cnt_q, cnt_d;
  logic        tone_q, tone_d;
  logic [16:0] cnt_inc;

  assign cnt_inc = {1'b0, cnt_q} + 17'd1;

  always_comb begin
    cnt_d  = cnt_q;
    tone_d = tone_q;
    if (tick_i) begin
      if (cnt_inc >= {1'b0, period_i}) begin
        cnt_d  = '0;
        tone_d = ~tone_q;
      end else begin
        cnt_d = cnt_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      tone_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      tone_q <= tone_d;
    end
  end

  // next value: the mixer samples it on the same tick
  assign tone_o = tone_d;

endmodule

// File: hw/rtl/tvsg_noise.sv
module tvsg_noise (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  logic [4:0] period_i,
  output logic       noise_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic [15:0] shift_q, shift_d;
  logic        out_q, out_d;
  logic [6:0]  cnt_inc;
  logic        fb;

  assign cnt_inc = {1'b0, cnt_q} + 7'd1;
  assign fb      = ~(out_q ^ shift_q[13]);

  always_comb begin
    cnt_d   = cnt_q;
    shift_d = shift_q;
    out_d   = out_q;
    if (tick_i) begin
      // noise period is twice the register value
      if (cnt_inc >= {1'b0, period_i, 1'b0}) begin
        cnt_d   = '0;
        shift_d = {shift_q[14:0], fb};
        out_d   = shift_q[15];
      end else begin
        cnt_d = cnt_inc[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      shift_q <= '0;
      out_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      out_q   <= out_d;
    end
  end

  assign noise_o = out_d;

endmodule

// File: hw/rtl/tvsg_env.sv
module tvsg_env (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tvsg_pkg::env_ctrl_t ctrl_i,
  input  logic [7:0]          shape_data_i,
  input  logic [15:0]         period_i,
  output logic [7:0]          shape_o,
  output logic [3:0]          level_o
);
  import tvsg_pkg::*;

  logic [16:0] cnt_q, cnt_d;
  logic [3:0]  lvl_q, lvl_d;
  logic        done_q, done_d;
  logic [7:0]  shape_q, shape_d;
  logic [17:0] cnt_inc;
  logic [3:0]  end_lvl;

  assign cnt_inc = {1'b0, cnt_q} + 18'd1;
  assign end_lvl = shape_q[SHAPE_ATTACK] ? 4'hF : 4'h0;

  always_comb begin
    cnt_d   = cnt_q;
    lvl_d   = lvl_q;
    done_d  = done_q;
    shape_d = shape_q;
    if (ctrl_i.shape_we) begin
      shape_d = shape_data_i;
      done_d  = 1'b0;
      lvl_d   = shape_data_i[SHAPE_ATTACK] ? 4'h0 : 4'hF;
    end else if (ctrl_i.tick) begin
      if (cnt_inc >= {1'b0, period_i, 1'b0}) begin
        cnt_d = '0;
        if (!done_q) begin
          if (lvl_q != end_lvl) begin
            lvl_d = shape_q[SHAPE_ATTACK] ? lvl_q + 4'd1 : lvl_q - 4'd1;
          end else begin
            done_d = 1'b1;
            if (!shape_q[SHAPE_CONTINUE]) begin
              // one-shot shapes settle at zero
              lvl_d = 4'h0;
            end else if (shape_q[SHAPE_HOLD]) begin
              if (shape_q[SHAPE_ALTERNATE]) begin
                lvl_d = ~lvl_q;
              end
            end else begin
              if (!shape_q[SHAPE_ALTERNATE]) begin
                lvl_d = ~lvl_q;
              end else begin
                shape_d[SHAPE_ATTACK] = ~shape_q[SHAPE_ATTACK];
              end
              done_d = 1'b0;
            end
          end
        end
      end else begin
        cnt_d = cnt_inc[16:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      lvl_q   <= '0;
      done_q  <= 1'b0;
      shape_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      lvl_q   <= lvl_d;
      done_q  <= done_d;
      shape_q <= shape_d;
    end
  end

  assign shape_o = shape_q;
  assign level_o = lvl_d;

endmodule

// File: hw/rtl/three_voice_sound_generator.sv
// channel | handshake             | word
// --------+-----------------------+------------------------------------------------
// in      | in_valid_i/in_ready_o | opcode_i, bus_data_i
// out     | out_valid_o/out_ready_i | level_a_o, level_b_o, level_c_o, read_byte_o,
//         |                       | read_valid_o
//
// One word per cycle while out_ready_i stays high; a taken input word passes
// from the input register through one pass of the generators into the result
// register, which drives the outputs; a stall holds it in the input register.
// Reset (rst_ni low) clears all but the payload registers at once.
// While out_ready_i is low the result is held and one more input word is
// buffered; in_ready_o drops only when both registers are full.
`include "three_voice_sound_generator_assert.svh"

module three_voice_sound_generator #(
  parameter int unsigned VOICES = tvsg_pkg::VOICES_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] bus_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] level_a_o,
  output logic [3:0] level_b_o,
  output logic [3:0] level_c_o,
  output logic [7:0] read_byte_o,
  output logic       read_valid_o
);
  import tvsg_pkg::*;

  // input register
  logic       in_valid_q;
  op_e        in_op_q;
  logic [7:0] in_data_q;

  // result register
  logic       out_valid_q;
  logic [3:0] res_lvl_q [MAX_VOICES];
  logic [7:0] res_byte_q;
  logic       res_rv_q;

  logic adv, fire, in_acc;

  // bus registers
  logic [3:0]  sel_q, sel_d;
  logic [15:0] tone_per_q [MAX_VOICES];
  logic [15:0] tone_per_d [MAX_VOICES];
  logic [7:0]  noise_per_q, noise_per_d;
  logic [7:0]  mixer_q, mixer_d;
  logic [7:0]  vol_q [MAX_VOICES];
  logic [7:0]  vol_d [MAX_VOICES];
  logic [15:0] env_per_q, env_per_d;

  logic [MAX_VOICES-1:0][3:0] lvl_q, lvl_d;

  logic [MAX_VOICES-1:0] tone_out;
  logic                  noise_out;
  logic [3:0]            env_lvl;
  logic [7:0]            env_shape;
  env_ctrl_t             env_ctrl;
  logic                  tick, wr;
  logic [7:0]            rd_byte;
  logic                  rd_valid;

  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && adv;
  assign in_ready_o = !in_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign tick = fire && (in_op_q == OP_TICK);
  assign wr   = fire && (in_op_q == OP_WRITE);

  assign env_ctrl.tick     = tick;
  assign env_ctrl.shape_we = wr && (sel_q == REG_ENV_SHAPE);

  for (genvar v = 0; v < MAX_VOICES; v++) begin : g_voice
    if (v < VOICES) begin : g_on
      tvsg_tone u_tone (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .tick_i   (tick),
        .period_i (tone_per_q[v]),
        .tone_o   (tone_out[v])
      );
    end else begin : g_off
      assign tone_out[v] = 1'b0;
    end
  end

  tvsg_noise u_noise (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .period_i (noise_per_q[4:0]),
    .noise_o  (noise_out)
  );

  tvsg_env u_env (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (env_ctrl),
    .shape_data_i (in_data_q),
    .period_i     (env_per_q),
    .shape_o      (env_shape),
    .level_o      (env_lvl)
  );

  // register select and writes
  always_comb begin
    sel_d       = sel_q;
    tone_per_d  = tone_per_q;
    noise_per_d = noise_per_q;
    mixer_d     = mixer_q;
    vol_d       = vol_q;
    env_per_d   = env_per_q;
    if (fire && (in_op_q == OP_SELECT) && (in_data_q[7:4] == 4'd0)) begin
      sel_d = in_data_q[3:0];
    end
    if (wr) begin
      case (sel_q)
        REG_TONE_A_LO: tone_per_d[0][7:0]  = in_data_q;
        REG_TONE_A_HI: tone_per_d[0][15:8] = in_data_q;
        REG_TONE_B_LO: tone_per_d[1][7:0]  = in_data_q;
        REG_TONE_B_HI: tone_per_d[1][15:8] = in_data_q;
        REG_TONE_C_LO: tone_per_d[2][7:0]  = in_data_q;
        REG_TONE_C_HI: tone_per_d[2][15:8] = in_data_q;
        REG_NOISE_PER: noise_per_d         = in_data_q;
        REG_MIXER:     mixer_d             = in_data_q;
        REG_VOL_A:     vol_d[0]            = in_data_q;
        REG_VOL_B:     vol_d[1]            = in_data_q;
        REG_VOL_C:     vol_d[2]            = in_data_q;
        REG_ENV_LO:    env_per_d[7:0]      = in_data_q;
        REG_ENV_HI:    env_per_d[15:8]     = in_data_q;
        default:       ;
      endcase
    end
  end

  // mixer: a disabled tone or noise source reads as high
  always_comb begin
    logic       t, n;
    logic [3:0] amp;
    lvl_d = lvl_q;
    for (int c = 0; c < MAX_VOICES; c++) begin
      t   = mixer_q[c] | tone_out[c];
      n   = mixer_q[c+3] | noise_out;
      amp = vol_q[c][VOL_ENV_BIT] ? env_lvl : vol_q[c][3:0];
      if (tick && (c < VOICES)) begin
        lvl_d[c] = (t && n) ? amp : 4'd0;
      end
    end
  end

  // read-back
  always_comb begin
    rd_byte  = 8'd0;
    rd_valid = (sel_q <= REG_ENV_SHAPE);
    case (sel_q)
      REG_TONE_A_LO: rd_byte = tone_per_q[0][7:0];
      REG_TONE_A_HI: rd_byte = tone_per_q[0][15:8];
      REG_TONE_B_LO: rd_byte = tone_per_q[1][7:0];
      REG_TONE_B_HI: rd_byte = tone_per_q[1][15:8];
      REG_TONE_C_LO: rd_byte = tone_per_q[2][7:0];
      REG_TONE_C_HI: rd_byte = tone_per_q[2][15:8];
      REG_NOISE_PER: rd_byte = noise_per_q;
      REG_MIXER:     rd_byte = mixer_q;
      REG_VOL_A:     rd_byte = vol_q[0];
      REG_VOL_B:     rd_byte = vol_q[1];
      REG_VOL_C:     rd_byte = vol_q[2];
      REG_ENV_LO:    rd_byte = env_per_q[7:0];
      REG_ENV_HI:    rd_byte = env_per_q[15:8];
      REG_ENV_SHAPE: rd_byte = env_shape;
      default:       rd_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= '0;
      noise_per_q <= '0;
      mixer_q     <= '0;
      env_per_q   <= '0;
      lvl_q       <= '0;
      for (int c = 0; c < MAX_VOICES; c++) begin
        tone_per_q[c] <= '0;
        vol_q[c]      <= '0;
      end
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      sel_q       <= sel_d;
      tone_per_q  <= tone_per_d;
      noise_per_q <= noise_per_d;
      mixer_q     <= mixer_d;
      vol_q       <= vol_d;
      env_per_q   <= env_per_d;
      lvl_q       <= lvl_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_op_q   <= op_e'(opcode_i);
      in_data_q <= bus_data_i;
    end
    if (fire) begin
      for (int c = 0; c < MAX_VOICES; c++) begin
        res_lvl_q[c] <= lvl_d[c];
      end
      res_byte_q <= (in_op_q == OP_READ && rd_valid) ? rd_byte : 8'd0;
      res_rv_q   <= (in_op_q == OP_READ) && rd_valid;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign level_a_o    = res_lvl_q[0];
  assign level_b_o    = res_lvl_q[1];
  assign level_c_o    = res_lvl_q[2];
  assign read_byte_o  = res_byte_q;
  assign read_valid_o = res_rv_q;

  `TVSG_ASSERT(a_fire_fills_out, clk_i, rst_ni, fire |=> out_valid_q, "result word lost")
  `TVSG_ASSERT(a_levels_only_on_tick, clk_i, rst_ni,
               (fire && in_op_q != OP_TICK) |=> $stable(lvl_q), "levels moved without tick")
  `TVSG_ASSERT(a_in_hold, clk_i, rst_ni,
               (in_valid_q && !adv) |=> (in_valid_q && $stable(in_op_q)), "input word dropped")
  `TVSG_ASSERT_NEVER(a_read_byte_zero, clk_i, rst_ni,
                     out_valid_o && !read_valid_o && read_byte_o != 8'd0,
                     "read byte without valid read")

endmodule

// File: verif/three_voice_sound_generator_tb.sv
module three_voice_sound_generator_tb;
  import tvsg_pkg::*;

  localparam int unsigned VOICES      = VOICES_DEFAULT;
  localparam int unsigned RAND_WORDS  = 1750;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_EVERY = 450;
  localparam logic [3:0]  REG_SPARE_0 = 4'd14;
  localparam logic [3:0]  REG_SPARE_1 = 4'd15;

  typedef struct {
    op_e        op;
    logic [7:0] data;
    bit         drain;  // hold this word back until every result is in
  } bus_word_t;

  typedef struct {
    logic [3:0] lvl_a;
    logic [3:0] lvl_b;
    logic [3:0] lvl_c;
    logic [7:0] rd_byte;
    logic       rd_valid;
  } gen_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] opcode_i;
  logic [7:0] bus_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [3:0] level_a_o;
  logic [3:0] level_b_o;
  logic [3:0] level_c_o;
  logic [7:0] read_byte_o;
  logic       read_valid_o;

  three_voice_sound_generator #(.VOICES(VOICES)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .bus_data_i   (bus_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .level_a_o    (level_a_o),
    .level_b_o    (level_b_o),
    .level_c_o    (level_c_o),
    .read_byte_o  (read_byte_o),
    .read_valid_o (read_valid_o)
  );

  always #4 clk_i = ~clk_i;

  bus_word_t   bus_words[$];
  gen_result_t pending_results[$];

  int unsigned words_total;
  int unsigned words_in;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned ticks_taken;
  int unsigned reads_hit;
  int unsigned shape_writes;
  int unsigned env_wraps;
  bit          drain_next;
  bit          word_taken;

  // generator state as predicted
  logic [3:0]  sel_reg;
  logic [15:0] tone_per [3];
  logic [7:0]  noise_per;
  logic [7:0]  mixer;
  logic [7:0]  vol [3];
  logic [15:0] env_per;
  logic [7:0]  env_shape;
  logic [15:0] tone_cnt [3];
  logic        tone_bit [3];
  logic [5:0]  noise_cnt;
  logic [15:0] noise_lfsr;
  logic        noise_bit;
  logic [16:0] env_cnt;
  logic [3:0]  env_lvl;
  logic        env_done;
  logic [3:0]  chan_lvl [3];

  initial begin
    sel_reg    = '0;
    noise_per  = '0;
    mixer      = '0;
    env_per    = '0;
    env_shape  = '0;
    noise_cnt  = '0;
    noise_lfsr = '0;
    noise_bit  = 1'b0;
    env_cnt    = '0;
    env_lvl    = '0;
    env_done   = 1'b0;
    for (int c = 0; c < 3; c++) begin
      tone_per[c] = '0;
      vol[c]      = '0;
      tone_cnt[c] = '0;
      tone_bit[c] = 1'b0;
      chan_lvl[c] = '0;
    end
  end

  task automatic step_envelope();
    logic [3:0] final_lvl;
    final_lvl = env_shape[SHAPE_ATTACK] ? 4'hF : 4'h0;
    if (env_done) return;
    if (env_lvl != final_lvl) begin
      env_lvl = env_shape[SHAPE_ATTACK] ? env_lvl + 4'd1 : env_lvl - 4'd1;
      return;
    end
    env_wraps++;
    env_done = 1'b1;
    if (!env_shape[SHAPE_CONTINUE]) begin
      env_lvl = 4'h0;
    end else if (env_shape[SHAPE_HOLD]) begin
      if (env_shape[SHAPE_ALTERNATE]) env_lvl = ~env_lvl;
    end else begin
      if (!env_shape[SHAPE_ALTERNATE]) env_lvl = ~env_lvl;
      else env_shape[SHAPE_ATTACK] = ~env_shape[SHAPE_ATTACK];
      env_done = 1'b0;
    end
  endtask

  task automatic advance_generators();
    logic [15:0] old;
    logic        t;
    logic        n;
    logic [3:0]  amp;
    for (int c = 0; c < VOICES && c < 3; c++) begin
      if ({1'b0, tone_cnt[c]} + 17'd1 >= {1'b0, tone_per[c]}) begin
        tone_cnt[c] = '0;
        tone_bit[c] = ~tone_bit[c];
      end else begin
        tone_cnt[c] = tone_cnt[c] + 16'd1;
      end
    end
    if ({1'b0, noise_cnt} + 7'd1 >= {1'b0, noise_per[4:0], 1'b0}) begin
      old        = noise_lfsr;
      noise_lfsr = {old[14:0], ~(noise_bit ^ old[13])};
      noise_bit  = old[15];
      noise_cnt  = '0;
    end else begin
      noise_cnt = noise_cnt + 6'd1;
    end
    if ({1'b0, env_cnt} + 18'd1 >= {1'b0, env_per, 1'b0}) begin
      env_cnt = '0;
      step_envelope();
    end else begin
      env_cnt = env_cnt + 17'd1;
    end
    for (int c = 0; c < VOICES && c < 3; c++) begin
      t   = mixer[c] ? 1'b1 : tone_bit[c];
      n   = mixer[c + 3] ? 1'b1 : noise_bit;
      amp = vol[c][VOL_ENV_BIT] ? env_lvl : vol[c][3:0];
      chan_lvl[c] = (t & n) ? amp : 4'h0;
    end
  endtask

  task automatic write_register(logic [7:0] v);
    case (sel_reg)
      REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: tone_per[sel_reg >> 1][7:0] = v;
      REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: tone_per[sel_reg >> 1][15:8] = v;
      REG_NOISE_PER: noise_per = v;
      REG_MIXER:     mixer = v;
      REG_VOL_A, REG_VOL_B, REG_VOL_C: vol[sel_reg - REG_VOL_A] = v;
      REG_ENV_LO:    env_per[7:0] = v;
      REG_ENV_HI:    env_per[15:8] = v;
      REG_ENV_SHAPE: begin
        env_shape = v;
        env_done  = 1'b0;
        env_lvl   = v[SHAPE_ATTACK] ? 4'h0 : 4'hF;
        shape_writes++;
      end
      default: ;
    endcase
  endtask

  function automatic logic [7:0] read_register();
    case (sel_reg)
      REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: return tone_per[sel_reg >> 1][7:0];
      REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: return tone_per[sel_reg >> 1][15:8];
      REG_NOISE_PER: return noise_per;
      REG_MIXER:     return mixer;
      REG_VOL_A, REG_VOL_B, REG_VOL_C: return vol[sel_reg - REG_VOL_A];
      REG_ENV_LO:    return env_per[7:0];
      REG_ENV_HI:    return env_per[15:8];
      REG_ENV_SHAPE: return env_shape;
      default:       return 8'h00;
    endcase
  endfunction

  task automatic apply_bus_word(op_e op, logic [7:0] data);
    gen_result_t r;
    r.rd_byte  = 8'h00;
    r.rd_valid = 1'b0;
    case (op)
      OP_TICK: begin
        advance_generators();
        ticks_taken++;
      end
      OP_SELECT: if (data < 8'd16) sel_reg = data[3:0];
      OP_WRITE:  write_register(data);
      default: begin
        if (sel_reg <= REG_ENV_SHAPE) begin
          r.rd_byte  = read_register();
          r.rd_valid = 1'b1;
          reads_hit++;
        end
      end
    endcase
    r.lvl_a = chan_lvl[0];
    r.lvl_b = chan_lvl[1];
    r.lvl_c = chan_lvl[2];
    pending_results.push_back(r);
  endtask

  task automatic push_word(op_e op, logic [7:0] data);
    bus_word_t w;
    w.op    = op;
    w.data  = data;
    w.drain = drain_next;
    drain_next = 1'b0;
    bus_words.push_back(w);
  endtask

  // keeps periods short enough that tones, noise and envelope all move
  function automatic logic [7:0] reg_byte(logic [3:0] r);
    case (r)
      REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO:
        return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI, REG_ENV_HI:
        return ($urandom_range(0, 9) < 9) ? 8'h00 : 8'($urandom);
      REG_ENV_LO:
        return ($urandom_range(0, 3) < 3) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      default:
        return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned pause_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // sender: a word stays on the bus until taken
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      apply_bus_word(op_e'(opcode_i), bus_data_i);
      words_in++;
      word_taken = 1'b1;
    end
  end

  int unsigned send_gap;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      if (word_taken && cycles[9] && $urandom_range(0, 9) < 3) send_gap = pause_len();
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (bus_words.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (bus_words[0].drain && pending_results.size() != 0) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        opcode_i   <= bus_words[0].op;
        bus_data_i <= bus_words[0].data;
        void'(bus_words.pop_front());
      end
    end
    word_taken = 1'b0;
  end

  // receiver: random stalls, plus two long hold-offs that back the block up
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned holds_done;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_left == 0 && ((holds_done == 0 && results_seen >= 400) ||
                             (holds_done == 1 && results_seen >= 1300))) begin
        hold_left = 150;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (cycles[8] && $urandom_range(0, 99) < 15) stall_left = pause_len();
      end
    end
  end

  always @(posedge clk_i) begin
    gen_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (level_a_o !== exp_r.lvl_a) begin
          $error("level_a: expected %0d, got %0d", exp_r.lvl_a, level_a_o);
          mismatches++;
        end
        if (level_b_o !== exp_r.lvl_b) begin
          $error("level_b: expected %0d, got %0d", exp_r.lvl_b, level_b_o);
          mismatches++;
        end
        if (level_c_o !== exp_r.lvl_c) begin
          $error("level_c: expected %0d, got %0d", exp_r.lvl_c, level_c_o);
          mismatches++;
        end
        if (read_byte_o !== exp_r.rd_byte) begin
          $error("read_byte: expected 0x%02h, got 0x%02h", exp_r.rd_byte, read_byte_o);
          mismatches++;
        end
        if (read_valid_o !== exp_r.rd_valid) begin
          $error("read_valid: expected %0d, got %0d", exp_r.rd_valid, read_valid_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [3:0]  r;
    int unsigned pick;
    int unsigned burst;
    int unsigned next_drain;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_TICK;
    bus_data_i  = 8'h00;
    out_ready_i = 1'b0;

    // directed: reset contents, ignored selects, spare registers, envelope start
    push_word(OP_READ, 8'h00);
    push_word(OP_SELECT, 8'hFF);
    push_word(OP_SELECT, 8'd16);
    push_word(OP_READ, 8'h00);
    push_word(OP_SELECT, {4'h0, REG_SPARE_0});
    push_word(OP_WRITE, 8'hFF);
    push_word(OP_READ, 8'h00);
    push_word(OP_SELECT, {4'h0, REG_SPARE_1});
    push_word(OP_READ, 8'h00);
    push_word(OP_SELECT, {4'h0, REG_TONE_A_LO});
    push_word(OP_WRITE, 8'h01);
    push_word(OP_SELECT, {4'h0, REG_VOL_A});
    push_word(OP_WRITE, 8'h0F);
    push_word(OP_SELECT, {4'h0, REG_ENV_SHAPE});
    push_word(OP_WRITE, 8'h0E);
    push_word(OP_SELECT, {4'h0, REG_VOL_B});
    push_word(OP_WRITE, 8'h1F);
    push_word(OP_SELECT, {4'h0, REG_MIXER});
    push_word(OP_WRITE, 8'h38);
    for (int i = 0; i < 4; i++) push_word(OP_TICK, 8'h00);
    push_word(OP_SELECT, {4'h0, REG_ENV_SHAPE});
    push_word(OP_READ, 8'h00);

    next_drain = bus_words.size() + DRAIN_EVERY;
    while (bus_words.size() < 25 + RAND_WORDS) begin
      if (bus_words.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst; i++) push_word(OP_TICK, 8'($urandom));
      end else if (pick < 75) begin
        r = 4'($urandom_range(0, 15));
        push_word(OP_SELECT, {4'h0, r});
        push_word(OP_WRITE, reg_byte(r));
      end else if (pick < 90) begin
        push_word(OP_SELECT, 8'($urandom_range(0, 15)));
        push_word(OP_READ, 8'($urandom));
      end else begin
        push_word(op_e'($urandom_range(0, 3)), 8'($urandom));
      end
    end
    words_total = bus_words.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (words_in != words_total) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d words in, %0d results checked: %0d ticks, %0d register reads",
             words_in, results_seen, ticks_taken, reads_hit);
    $display("%0d envelope shape writes, %0d envelope end events, %0d mismatches",
             shape_writes, env_wraps, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
